@@ src/tws_pkg.sv @@
// Shared types and phase codes for the three-wire serial master.
// No dependencies; compiled first.
package tws_pkg;

   localparam int PhaseWidth = 4;

   // Pin sequencer phase codes
   localparam logic [PhaseWidth-1:0] ST_IDLE    = 4'd0;
   localparam logic [PhaseWidth-1:0] ST_CE_LOW  = 4'd1;
   localparam logic [PhaseWidth-1:0] ST_CLK_LOW = 4'd2;
   localparam logic [PhaseWidth-1:0] ST_CE_HIGH = 4'd3;
   localparam logic [PhaseWidth-1:0] ST_TX_BIT  = 4'd4;
   localparam logic [PhaseWidth-1:0] ST_TX_RISE = 4'd5;
   localparam logic [PhaseWidth-1:0] ST_TX_FALL = 4'd6;
   localparam logic [PhaseWidth-1:0] ST_RELEASE = 4'd7;
   localparam logic [PhaseWidth-1:0] ST_RX_BIT  = 4'd8;
   localparam logic [PhaseWidth-1:0] ST_RX_RISE = 4'd9;
   localparam logic [PhaseWidth-1:0] ST_RX_FALL = 4'd10;
   localparam logic [PhaseWidth-1:0] ST_RETAKE  = 4'd11;
   localparam logic [PhaseWidth-1:0] ST_END_CLK = 4'd12;
   localparam logic [PhaseWidth-1:0] ST_END_CE  = 4'd13;

   localparam logic [2:0] LAST_BIT = 3'd7;

   typedef struct packed {
      logic [PhaseWidth-1:0] phase;
      logic [2:0]            bit_count;
      logic                  byte_select;
      logic                  is_read;
      logic [7:0]            transmit_shift;
      logic [7:0]            data_hold;
      logic [7:0]            receive_shift;
      logic [7:0]            divider_count;
      logic                  chip_enable;
      logic                  serial_clock;
      logic                  data_pin_out;
      logic                  data_pin_drive;
   } tws_state_type;

   localparam tws_state_type STATE_RESET = '{
      phase:          ST_IDLE,
      bit_count:      3'd0,
      byte_select:    1'b0,
      is_read:        1'b0,
      transmit_shift: 8'd0,
      data_hold:      8'd0,
      receive_shift:  8'd0,
      divider_count:  8'd0,
      chip_enable:    1'b0,
      serial_clock:   1'b0,
      data_pin_out:   1'b0,
      data_pin_drive: 1'b1
   };

endpackage

@@ src/tws_if.sv @@
// Handshake channel interfaces for the three-wire serial master.
// Standalone; used by the top level ports.
interface tws_req_if;
   logic       valid;
   logic       ready;
   logic       start_req;
   logic       opcode;
   logic [7:0] command_byte;
   logic [7:0] write_byte;
   logic       data_pin_in;

   modport source (output valid, start_req, opcode, command_byte, write_byte, data_pin_in,
                   input ready);
   modport sink   (input valid, start_req, opcode, command_byte, write_byte, data_pin_in,
                   output ready);
endinterface

interface tws_rsp_if;
   logic       valid;
   logic       ready;
   logic       chip_enable;
   logic       serial_clock;
   logic       data_pin_out;
   logic       data_pin_drive;
   logic       busy_res;
   logic       done_res;
   logic [7:0] read_byte;

   modport source (output valid, chip_enable, serial_clock, data_pin_out, data_pin_drive,
                   busy_res, done_res, read_byte,
                   input ready);
   modport sink   (input valid, chip_enable, serial_clock, data_pin_out, data_pin_drive,
                   busy_res, done_res, read_byte,
                   output ready);
endinterface

interface tws_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] ticks_per_phase;

   modport source (output valid, ticks_per_phase, input ready);
   modport sink   (input valid, ticks_per_phase, output ready);
endinterface

@@ src/tws_step.sv @@
// Next-state logic of the pin sequencer: one tick in, next state out.
// Depends on tws_pkg.
module tws_step
   import tws_pkg::*;
(
   input  tws_state_type cur,
   input  logic [7:0]    ticks_per_phase,
   input  logic          start_req,
   input  logic          opcode,
   input  logic [7:0]    command_byte,
   input  logic [7:0]    write_byte,
   input  logic          data_pin_in,
   output tws_state_type nxt,
   output logic          done
);

   logic [7:0]            hold;
   logic                  enter;
   logic [PhaseWidth-1:0] step_to;

   assign hold = (ticks_per_phase == 8'd0) ? 8'd1 : ticks_per_phase;

   always_comb begin
      nxt     = cur;
      done    = 1'b0;
      enter   = 1'b0;
      step_to = cur.phase;

      if (cur.phase == ST_IDLE) begin
         if (start_req) begin
            nxt.is_read        = opcode;
            nxt.transmit_shift = opcode ? (command_byte | 8'h01) : command_byte;
            nxt.data_hold      = write_byte;
            enter              = 1'b1;
            step_to            = ST_CE_LOW;
         end
      end else if (cur.divider_count >= hold) begin
         unique case (cur.phase)
            ST_TX_FALL: begin
               nxt.transmit_shift = cur.transmit_shift >> 1;
               enter              = 1'b1;
               if (cur.bit_count != LAST_BIT) begin
                  nxt.bit_count = cur.bit_count + 3'd1;
                  step_to       = ST_TX_BIT;
               end else begin
                  nxt.bit_count = 3'd0;
                  if (!cur.byte_select) begin
                     if (cur.is_read) begin
                        step_to = ST_RELEASE;
                     end else begin
                        // command done, load the data byte
                        nxt.byte_select    = 1'b1;
                        nxt.transmit_shift = cur.data_hold;
                        step_to            = ST_TX_BIT;
                     end
                  end else begin
                     step_to = ST_END_CLK;
                  end
               end
            end
            ST_RX_FALL: begin
               enter = 1'b1;
               if (cur.bit_count != LAST_BIT) begin
                  nxt.bit_count = cur.bit_count + 3'd1;
                  step_to       = ST_RX_BIT;
               end else begin
                  nxt.bit_count = 3'd0;
                  step_to       = ST_RETAKE;
               end
            end
            default: begin
               if (cur.phase >= ST_END_CE) begin
                  nxt.phase         = ST_IDLE;
                  nxt.divider_count = 8'd0;
                  done              = 1'b1;
               end else begin
                  enter   = 1'b1;
                  step_to = cur.phase + 4'd1;
               end
            end
         endcase
      end else begin
         nxt.divider_count = cur.divider_count + 8'd1;
      end

      if (enter) begin
         nxt.phase         = step_to;
         nxt.divider_count = 8'd1;
         unique case (step_to)
            ST_CE_LOW:  nxt.chip_enable  = 1'b0;
            ST_CLK_LOW: nxt.serial_clock = 1'b0;
            ST_CE_HIGH: begin
               nxt.chip_enable = 1'b1;
               nxt.bit_count   = 3'd0;
               nxt.byte_select = 1'b0;
            end
            ST_TX_BIT:  nxt.data_pin_out = nxt.transmit_shift[0];
            ST_TX_RISE, ST_RX_RISE, ST_END_CLK: nxt.serial_clock = 1'b1;
            ST_TX_FALL, ST_RX_FALL: nxt.serial_clock = 1'b0;
            ST_RELEASE: begin
               nxt.data_pin_drive = 1'b0;
               nxt.receive_shift  = 8'd0;
               nxt.bit_count      = 3'd0;
            end
            ST_RX_BIT:  nxt.receive_shift = {data_pin_in, cur.receive_shift[7:1]};
            ST_RETAKE:  nxt.data_pin_drive = 1'b1;
            ST_END_CE:  nxt.chip_enable = 1'b0;
            default: ;
         endcase
      end
   end

endmodule

@@ src/three_wire_serial_master.sv @@
// Three-wire serial master, LSB first. One tick item in, one pin-level item out.
// One item per cycle while the result is taken; the result is valid the cycle after acceptance,
// set by the single state/result register stage around the next-state logic.
// A stalled result blocks intake only while it is not taken in the same cycle.
// Reset (synchronous, active high): sequencer idle, pins enable low, clock low,
// data driven low, phase length 1, no result pending.
module three_wire_serial_master
   import tws_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   tws_req_if.sink   req_chan,
   tws_rsp_if.source rsp_chan,
   tws_csr_if.sink   csr_chan
);

   tws_state_type state_ff, state_in;
   logic [7:0]    ticks_ff;
   logic          rsp_valid_ff;
   logic          done_ff, done_in;
   logic          accept;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign csr_chan.ready = 1'b1;
   assign accept         = req_chan.valid && req_chan.ready;

   tws_step u_step (
      .cur             (state_ff),
      .ticks_per_phase (ticks_ff),
      .start_req       (req_chan.start_req),
      .opcode          (req_chan.opcode),
      .command_byte    (req_chan.command_byte),
      .write_byte      (req_chan.write_byte),
      .data_pin_in     (req_chan.data_pin_in),
      .nxt             (state_in),
      .done            (done_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= STATE_RESET;
         ticks_ff     <= 8'd1;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_chan.valid) begin
            ticks_ff <= csr_chan.ticks_per_phase;
         end
         if (accept) begin
            state_ff     <= state_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // done pulse is carried with the item
   always_ff @(posedge clock) begin
      if (accept) begin
         done_ff <= done_in;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.chip_enable    = state_ff.chip_enable;
   assign rsp_chan.serial_clock   = state_ff.serial_clock;
   assign rsp_chan.data_pin_out   = state_ff.data_pin_out;
   assign rsp_chan.data_pin_drive = state_ff.data_pin_drive;
   assign rsp_chan.busy_res       = (state_ff.phase != ST_IDLE);
   assign rsp_chan.done_res       = done_ff;
   assign rsp_chan.read_byte      = state_ff.receive_shift;

endmodule

@@ src/tws_checker.sv @@
// Port-level checks for three_wire_serial_master, attached by bind.
// Depends on the top level and its channel interfaces.
module tws_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       chip_enable,
   input logic       data_pin_drive,
   input logic       busy_res,
   input logic       done_res,
   input logic [7:0] read_byte
);

   // a completing item is never also busy
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(done_res && busy_res))
      else $error("done and busy both set");

   // enable high only inside a transaction
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && chip_enable) |-> busy_res)
      else $error("chip enable high while idle");

   // pin released only inside a transaction
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !data_pin_drive) |-> busy_res)
      else $error("data pin released while idle");

   // stalled item holds
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(read_byte) && $stable(done_res)))
      else $error("stalled item changed");

   // no result without an item after reset
   assert property (@(posedge clock)
      (reset || (!req_valid && !rsp_valid)) |=> !rsp_valid)
      else $error("result without an item");

endmodule

bind three_wire_serial_master tws_checker u_tws_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_chan.valid),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .chip_enable    (rsp_chan.chip_enable),
   .data_pin_drive (rsp_chan.data_pin_drive),
   .busy_res       (rsp_chan.busy_res),
   .done_res       (rsp_chan.done_res),
   .read_byte      (rsp_chan.read_byte)
);
